@@ design/phs_pkg.sv @@
// ---------------------------------------------------------------------------
// phs_pkg
// Shared types and constants for the palette HSV shift unit.
// ---------------------------------------------------------------------------
package phs_pkg;

    localparam int HUE_FULL   = 23040;
    localparam int HUE_SECTOR = 3840;
    localparam int UNIT       = 4096;
    localparam int SAT_FLOOR  = 41;

    // restoring divider geometry: numerator bits and quotient bits
    localparam int NUM_W = 23;
    localparam int QUO_W = 15;

    // configuration register indexes
    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_SAT_LOW  = 3'd1;
    localparam logic [2:0] REG_VAL_LOW  = 3'd2;
    localparam logic [2:0] REG_HUE_HIGH = 3'd3;
    localparam logic [2:0] REG_SAT_HIGH = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;

    typedef struct packed {
        logic [7:0] entry_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } phs_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } phs_out_t;

    typedef struct packed {
        logic signed [15:0] hue;
        logic signed [12:0] sat;
        logic signed [12:0] val;
    } phs_shift_t;

    // data that rides alongside the dividers
    typedef struct packed {
        logic        bypass;
        logic [23:0] rgb;
        logic [12:0] val;
        phs_shift_t  shift;
    } phs_side_t;

endpackage

@@ design/phs_front.sv @@
// ---------------------------------------------------------------------------
// phs_front
// First stage: max/min, value, hue numerator and divider operands.
// ---------------------------------------------------------------------------
module phs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  phs_pkg::phs_in_t            item,
    input  phs_pkg::phs_shift_t         shift_low,
    input  phs_pkg::phs_shift_t         shift_high,
    output logic                        valid_reg,
    output phs_pkg::phs_side_t          side_reg,
    output logic [phs_pkg::NUM_W-1:0]   hnum_reg,
    output logic [7:0]                  hden_reg,
    output logic [phs_pkg::NUM_W-1:0]   snum_reg,
    output logic [7:0]                  sden_reg
);

    logic [7:0]         r, g, b, mx, mn, d;
    logic signed [24:0] rs, gs, bs, dd, tot;
    logic [11:0]        y;
    logic [12:0]        ysum;
    logic [12:0]        v;
    phs_pkg::phs_side_t side_next;

    always_comb
    begin
        r = item.red_in;
        g = item.green_in;
        b = item.blue_in;
        mx = (r > g) ? r : g;
        if (b > mx)
        begin
            mx = b;
        end
        mn = (r < g) ? r : g;
        if (b < mn)
        begin
            mn = b;
        end
        d  = mx - mn;
        rs = {17'd0, r};
        gs = {17'd0, g};
        bs = {17'd0, b};
        dd = {17'd0, d};
        if (r == mx)
        begin
            tot = 25'sd3840 * (gs - bs);
        end
        else if (g == mx)
        begin
            tot = 25'sd7680 * dd + 25'sd3840 * (bs - rs);
        end
        else
        begin
            tot = 25'sd15360 * dd + 25'sd3840 * (rs - gs);
        end
        if (tot < 0)
        begin
            tot = tot + 25'sd23040 * dd;
        end
        // mx*4096/255 = 16*mx + floor(16*mx/255)
        y    = {mx, 4'd0};
        ysum = {1'b0, y} + {5'd0, y[11:8]} + 13'd1;
        v    = {1'b0, y} + {8'd0, ysum[12:8]};

        side_next.bypass = (item.entry_index[7:6] != 2'b11) || (mx == mn);
        side_next.rgb    = {r, g, b};
        side_next.val    = v;
        side_next.shift  = item.entry_index[5] ? shift_high : shift_low;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        hnum_reg <= tot[phs_pkg::NUM_W-1:0];
        hden_reg <= d;
        snum_reg <= {3'd0, d, 12'd0};
        sden_reg <= mx;
    end

endmodule

@@ design/phs_div.sv @@
// ---------------------------------------------------------------------------
// phs_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module phs_div #(
    parameter int NW = 23,
    parameter int DW = 8,
    parameter int QW = 15
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [NW-1:0]    rem_src;
        logic [DW-1:0]    den_src;
        logic [QW-1:0]    q_src;
        logic [NW+QW-1:0] trial;
        logic             ge;
        logic [NW-1:0]    rem_next;
        logic [QW-1:0]    q_next;

        if (k == 0)
        begin : g_first
            assign rem_src = num;
            assign den_src = den;
            assign q_src   = '0;
        end
        else
        begin : g_rest
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign q_src   = q_reg[k-1];
        end

        always_comb
        begin
            trial    = {{(NW+QW-DW){1'b0}}, den_src} << (QW - 1 - k);
            ge       = ({{QW{1'b0}}, rem_src} >= trial);
            rem_next = ge ? (rem_src - trial[NW-1:0]) : rem_src;
            q_next   = q_src;
            q_next[QW-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_src;
            q_reg[k]   <= q_next;
        end
    end

    assign quo = q_reg[QW-1];

endmodule

@@ design/phs_back.sv @@
// ---------------------------------------------------------------------------
// phs_back
// Offset/wrap stage and three stages of HSV to RGB conversion.
// ---------------------------------------------------------------------------
module phs_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  phs_pkg::phs_side_t        side,
    input  logic [phs_pkg::QUO_W-1:0] h_quo,
    input  logic [phs_pkg::QUO_W-1:0] s_quo,
    output logic                      out_valid_reg,
    output phs_pkg::phs_out_t         result_reg
);

    localparam logic [23:0] FULL_M = 24'd15728640;

    // wrap stage
    logic signed [17:0] hsum;
    logic [16:0]        hpos, hw;
    logic signed [13:0] ssum, vsum;
    logic [12:0]        s_w, v_w;
    logic [2:0]         sec_next;
    logic [11:0]        f_next;

    logic        w_valid_reg, w_bypass_reg;
    logic [23:0] w_rgb_reg;
    logic [2:0]  w_sec_reg;
    logic [11:0] w_f_reg;
    logic [12:0] w_s_reg, w_v_reg;

    always_comb
    begin
        // biased by two turns so the sum is never negative
        hsum = {3'd0, h_quo} + {{2{side.shift.hue[15]}}, side.shift.hue} + 18'sd46080;
        hpos = hsum[16:0];
        if (hpos >= 17'd92160)
        begin
            hw = hpos - 17'd92160;
        end
        else if (hpos >= 17'd69120)
        begin
            hw = hpos - 17'd69120;
        end
        else if (hpos >= 17'd46080)
        begin
            hw = hpos - 17'd46080;
        end
        else if (hpos >= 17'd23040)
        begin
            hw = hpos - 17'd23040;
        end
        else
        begin
            hw = hpos;
        end

        ssum = {1'b0, s_quo[12:0]} + {side.shift.sat[12], side.shift.sat};
        if (ssum > 14'sd4096)
        begin
            ssum = ssum - 14'sd4096;
        end
        if (ssum < 0)
        begin
            ssum = ssum + 14'sd4096;
        end
        s_w = (ssum == 0) ? 13'(phs_pkg::SAT_FLOOR) : ssum[12:0];

        vsum = {1'b0, side.val} + {side.shift.val[12], side.shift.val};
        if (vsum > 14'sd4096)
        begin
            vsum = vsum - 14'sd4096;
        end
        if (vsum < 0)
        begin
            vsum = vsum + 14'sd4096;
        end
        v_w = vsum[12:0];

        if (hw >= 17'd19200)
        begin
            sec_next = 3'd5;
            f_next   = 12'(hw - 17'd19200);
        end
        else if (hw >= 17'd15360)
        begin
            sec_next = 3'd4;
            f_next   = 12'(hw - 17'd15360);
        end
        else if (hw >= 17'd11520)
        begin
            sec_next = 3'd3;
            f_next   = 12'(hw - 17'd11520);
        end
        else if (hw >= 17'd7680)
        begin
            sec_next = 3'd2;
            f_next   = 12'(hw - 17'd7680);
        end
        else if (hw >= 17'd3840)
        begin
            sec_next = 3'd1;
            f_next   = 12'(hw - 17'd3840);
        end
        else
        begin
            sec_next = 3'd0;
            f_next   = hw[11:0];
        end
    end

    // products stage
    logic        m1_valid_reg, m1_bypass_reg;
    logic [23:0] m1_rgb_reg;
    logic [2:0]  m1_sec_reg;
    logic [12:0] m1_v_reg;
    logic [24:0] m1_sf_reg, m1_st_reg, m1_sp_reg;

    // v times factor stage
    logic        m2_valid_reg, m2_bypass_reg;
    logic [23:0] m2_rgb_reg;
    logic [2:0]  m2_sec_reg;
    logic [36:0] m2_pv_reg, m2_pp_reg, m2_pq_reg, m2_pt_reg;
    logic [23:0] mp, mq, mt;

    // final byte: v*m*255/(2^24*3840) = v*m*17 >> 32
    logic [41:0]       xv, xp, xq, xt;
    logic [7:0]        bv, bp, bq, bt;
    phs_pkg::phs_out_t res_next;

    always_comb
    begin
        mp = FULL_M - m1_sp_reg[23:0];
        mq = FULL_M - m1_sf_reg[23:0];
        mt = FULL_M - m1_st_reg[23:0];

        xv = {5'd0, m2_pv_reg} + {1'b0, m2_pv_reg, 4'd0};
        xp = {5'd0, m2_pp_reg} + {1'b0, m2_pp_reg, 4'd0};
        xq = {5'd0, m2_pq_reg} + {1'b0, m2_pq_reg, 4'd0};
        xt = {5'd0, m2_pt_reg} + {1'b0, m2_pt_reg, 4'd0};
        bv = xv[39:32];
        bp = xp[39:32];
        bq = xq[39:32];
        bt = xt[39:32];

        case (m2_sec_reg)
            3'd0:    res_next = '{red_out: bv, green_out: bt, blue_out: bp};
            3'd1:    res_next = '{red_out: bq, green_out: bv, blue_out: bp};
            3'd2:    res_next = '{red_out: bp, green_out: bv, blue_out: bt};
            3'd3:    res_next = '{red_out: bp, green_out: bq, blue_out: bv};
            3'd4:    res_next = '{red_out: bt, green_out: bp, blue_out: bv};
            default: res_next = '{red_out: bv, green_out: bp, blue_out: bq};
        endcase
        if (m2_bypass_reg)
        begin
            res_next = m2_rgb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg   <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_valid_reg   <= in_valid;
            m1_valid_reg  <= w_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_bypass_reg  <= side.bypass;
        w_rgb_reg     <= side.rgb;
        w_sec_reg     <= sec_next;
        w_f_reg       <= f_next;
        w_s_reg       <= s_w;
        w_v_reg       <= v_w;

        m1_bypass_reg <= w_bypass_reg;
        m1_rgb_reg    <= w_rgb_reg;
        m1_sec_reg    <= w_sec_reg;
        m1_v_reg      <= w_v_reg;
        m1_sf_reg     <= w_s_reg * w_f_reg;
        m1_st_reg     <= w_s_reg * (12'd3840 - w_f_reg);
        m1_sp_reg     <= w_s_reg * 12'd3840;

        m2_bypass_reg <= m1_bypass_reg;
        m2_rgb_reg    <= m1_rgb_reg;
        m2_sec_reg    <= m1_sec_reg;
        m2_pv_reg     <= m1_v_reg * FULL_M;
        m2_pp_reg     <= m1_v_reg * mp;
        m2_pq_reg     <= m1_v_reg * mq;
        m2_pt_reg     <= m1_v_reg * mt;

        result_reg    <= res_next;
    end

endmodule

@@ design/palette_hsv_shift_unit.sv @@
// ---------------------------------------------------------------------------
// palette_hsv_shift_unit
// Hue/saturation/value offset of palette entries, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   signals                        handshake
//  request   start, busy, entry             taken when start & !busy
//  result    done, result                   one cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready,          written when cfg_valid & cfg_ready
//            cfg_index, cfg_data
//
//  One request per cycle; busy is always low.
//  The pipeline holds one setup stage, 15 restoring divider stages
//  (hue and saturation quotients), a wrap stage and three multiply stages.
//  Reset clears the valid bits and all offset registers.
// ---------------------------------------------------------------------------
module palette_hsv_shift_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  phs_pkg::phs_in_t  entry,
    output logic              done,
    output phs_pkg::phs_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int QW = phs_pkg::QUO_W;

    phs_pkg::phs_shift_t shift_low_reg, shift_high_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_low_reg  <= '0;
            shift_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                phs_pkg::REG_HUE_LOW:  shift_low_reg.hue  <= cfg_data;
                phs_pkg::REG_SAT_LOW:  shift_low_reg.sat  <= cfg_data[12:0];
                phs_pkg::REG_VAL_LOW:  shift_low_reg.val  <= cfg_data[12:0];
                phs_pkg::REG_HUE_HIGH: shift_high_reg.hue <= cfg_data;
                phs_pkg::REG_SAT_HIGH: shift_high_reg.sat <= cfg_data[12:0];
                phs_pkg::REG_VAL_HIGH: shift_high_reg.val <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic                      f_valid;
    phs_pkg::phs_side_t        f_side;
    logic [phs_pkg::NUM_W-1:0] hnum, snum;
    logic [7:0]                hden, sden;

    phs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .item       (entry),
        .shift_low  (shift_low_reg),
        .shift_high (shift_high_reg),
        .valid_reg  (f_valid),
        .side_reg   (f_side),
        .hnum_reg   (hnum),
        .hden_reg   (hden),
        .snum_reg   (snum),
        .sden_reg   (sden)
    );

    logic [QW-1:0] h_quo, s_quo;

    phs_div #(.NW(phs_pkg::NUM_W), .DW(8), .QW(QW)) u_hdiv (
        .clk (clk),
        .num (hnum),
        .den (hden),
        .quo (h_quo)
    );

    phs_div #(.NW(phs_pkg::NUM_W), .DW(8), .QW(QW)) u_sdiv (
        .clk (clk),
        .num (snum),
        .den (sden),
        .quo (s_quo)
    );

    // side data and valid bits matched to divider depth
    logic               dv_reg   [QW];
    phs_pkg::phs_side_t side_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dv_reg[0] <= f_valid;
            for (int i = 1; i < QW; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= f_side;
        for (int i = 1; i < QW; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    phs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (dv_reg[QW-1]),
        .side          (side_reg[QW-1]),
        .h_quo         (h_quo),
        .s_quo         (s_quo),
        .out_valid_reg (done),
        .result_reg    (result)
    );

endmodule

@@ design/phs_checker.sv @@
// ---------------------------------------------------------------------------
// phs_checker
// Port-level checks on latency and pass-through entries.
// ---------------------------------------------------------------------------
module phs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input phs_pkg::phs_in_t  entry,
    input logic              done,
    input phs_pkg::phs_out_t result
);

    localparam int LATENCY = 20;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("request without result");

    a_done_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without request");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (start && entry.entry_index < 8'd192) |-> ##LATENCY
        (result.red_out == $past(entry.red_in, LATENCY) &&
         result.green_out == $past(entry.green_in, LATENCY) &&
         result.blue_out == $past(entry.blue_in, LATENCY)))
        else $error("pass-through entry altered");

endmodule

bind palette_hsv_shift_unit phs_checker u_phs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .entry  (entry),
    .done   (done),
    .result (result)
);
